>>> src/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

  localparam int SYM_W = 8;
  localparam int OUT_POS_W = 16;

  typedef enum logic [2:0] {
    ST_BALANCED       = 3'd0,
    ST_WRONG_CLOSER   = 3'd1,
    ST_MISSING_OPENER = 3'd2,
    ST_MISSING_CLOSER = 3'd3,
    ST_OVERFLOW       = 3'd4
  } status_t;

  typedef logic [1:0] br_code_t;

  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [SYM_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [SYM_W-1:0] CH_RANGLE = 8'h3E;

  localparam br_code_t BR_PAREN = 2'd0;
  localparam br_code_t BR_BRACE = 2'd1;
  localparam br_code_t BR_BRACK = 2'd2;
  localparam br_code_t BR_ANGLE = 2'd3;

  typedef struct packed {
    logic     hit;
    br_code_t code;
  } br_decode_t;

  typedef struct packed {
    status_t                status;
    logic [OUT_POS_W-1:0]   position;
    logic [SYM_W-1:0]       expected;
  } bbc_result_t;

  function automatic br_decode_t decode_opener(input logic [SYM_W-1:0] sym);
    br_decode_t d;
    d = '{hit: 1'b1, code: BR_PAREN};
    unique case (sym)
      CH_LPAREN: d.code = BR_PAREN;
      CH_LBRACE: d.code = BR_BRACE;
      CH_LBRACK: d.code = BR_BRACK;
      CH_LANGLE: d.code = BR_ANGLE;
      default:   d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic br_decode_t decode_closer(input logic [SYM_W-1:0] sym);
    br_decode_t d;
    d = '{hit: 1'b1, code: BR_PAREN};
    unique case (sym)
      CH_RPAREN: d.code = BR_PAREN;
      CH_RBRACE: d.code = BR_BRACE;
      CH_RBRACK: d.code = BR_BRACK;
      CH_RANGLE: d.code = BR_ANGLE;
      default:   d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [SYM_W-1:0] opener_char(input br_code_t c);
    logic [SYM_W-1:0] ch;
    unique case (c)
      BR_PAREN: ch = CH_LPAREN;
      BR_BRACE: ch = CH_LBRACE;
      BR_BRACK: ch = CH_LBRACK;
      default:  ch = CH_LANGLE;
    endcase
    return ch;
  endfunction

  function automatic logic [SYM_W-1:0] closer_char(input br_code_t c);
    logic [SYM_W-1:0] ch;
    unique case (c)
      BR_PAREN: ch = CH_RPAREN;
      BR_BRACE: ch = CH_RBRACE;
      BR_BRACK: ch = CH_RBRACK;
      default:  ch = CH_RANGLE;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> src/bbc_in_if.sv
`default_nettype none

interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

>>> src/bbc_out_if.sv
`default_nettype none

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] position;
  logic [7:0]  expected;

  modport source (output valid, output status, output position, output expected, input ready);
  modport sink (input valid, input status, input position, input expected, output ready);
endinterface

`default_nettype wire

>>> src/bracket_balance_checker.sv
// Bracket balance checker.
// in_ch carries one byte of a string per item (symbol) with last marking the
// final byte. Openers ( { [ < are pushed, matching closers ) } ] > pop, all
// other bytes are ignored. The first error of a string is latched with its
// byte index; later bytes of that string only advance the index.
// out_ch carries one verdict item per string, issued for the last byte:
// status, position (saturating at 65535) and the expected/missing symbol.
// Throughput: one byte per cycle while out_ch is not stalled. Each byte costs at
// most one push or one pop of the stack RAM; the top entry sits in a register and
// the RAM is read one entry below it ahead of time, so consecutive pops need no stall.
// The verdict is registered and appears on out_ch in the cycle after the last
// byte is taken. Non-final bytes give no output item.
// A single output register parts the channels: in_ch.ready stays high while
// that register is empty or being drained, and drops only while a verdict
// waits on a stalled receiver.
// Reset (synchronous, active low) empties the stack, clears the byte index and
// the error latch, and drops out_ch.valid. The stack RAM needs no clearing.
`default_nettype none

module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int POSITION_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  bbc_in_if.sink   in_ch,
  bbc_out_if.source out_ch
);

  logic        accept;
  logic        res_valid;
  bbc_result_t result;
  logic        out_valid_r, out_valid_nxt;
  bbc_result_t out_data_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  bbc_core #(
    .STACK_DEPTH   (STACK_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .symbol    (in_ch.symbol),
    .last      (in_ch.last),
    .res_valid (res_valid),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_data_r.status;
  assign out_ch.position = out_data_r.position;
  assign out_ch.expected = out_data_r.expected;

endmodule

`default_nettype wire

>>> src/bbc_ram.sv
`default_nettype none

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/bbc_core.sv
`default_nettype none

module bbc_core
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int POSITION_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             last,
  output logic                  res_valid,
  output bbc_result_t           result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1) + 1;
  localparam int PW = POSITION_BITS;

  logic [DW-1:0]    depth_r, depth_nxt;
  br_code_t         top_r, top_nxt;
  logic [PW-1:0]    idx_r, idx_nxt, idx_inc;
  logic             err_r, err_nxt;
  status_t          err_status_r, err_status_nxt;
  logic [PW-1:0]    err_pos_r, err_pos_nxt;
  logic [SYM_W-1:0] err_sym_r, err_sym_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  br_code_t         rdata;
  logic [DW-1:0]    raddr_full;
  br_decode_t       op, cl;
  logic [PW-1:0]    pos_sel;

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (op.code),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    op             = decode_opener(symbol);
    cl             = decode_closer(symbol);
    depth_nxt      = depth_r;
    top_nxt        = top_r;
    err_nxt        = err_r;
    err_status_nxt = err_status_r;
    err_pos_nxt    = err_pos_r;
    err_sym_nxt    = err_sym_r;
    we             = 1'b0;
    waddr          = depth_r[AW-1:0];
    idx_inc        = (idx_r == {PW{1'b1}}) ? idx_r : idx_r + PW'(1);
    idx_nxt        = idx_r;

    if (accept) begin
      idx_nxt = idx_inc;
      if (!err_r) begin
        if (op.hit) begin
          if (depth_r == DW'(STACK_DEPTH)) begin
            err_nxt        = 1'b1;
            err_status_nxt = ST_OVERFLOW;
            err_pos_nxt    = idx_r;
            err_sym_nxt    = symbol;
          end else begin
            we        = 1'b1;
            depth_nxt = depth_r + DW'(1);
            top_nxt   = op.code;
          end
        end else if (cl.hit) begin
          if (depth_r == '0) begin
            err_nxt        = 1'b1;
            err_status_nxt = ST_MISSING_OPENER;
            err_pos_nxt    = idx_r;
            err_sym_nxt    = opener_char(cl.code);
          end else if (top_r != cl.code) begin
            err_nxt        = 1'b1;
            err_status_nxt = ST_WRONG_CLOSER;
            err_pos_nxt    = idx_r;
            err_sym_nxt    = closer_char(top_r);
          end else begin
            depth_nxt = depth_r - DW'(1);
            top_nxt   = rdata;
          end
        end
      end
    end

    res_valid = accept && last;
    if (err_nxt) begin
      result.status   = err_status_nxt;
      pos_sel         = err_pos_nxt;
      result.expected = err_sym_nxt;
    end else if (depth_nxt == '0) begin
      result.status   = ST_BALANCED;
      pos_sel         = '0;
      result.expected = '0;
    end else begin
      result.status   = ST_MISSING_CLOSER;
      pos_sel         = idx_inc;
      result.expected = closer_char(top_nxt);
    end
    if ((pos_sel >> OUT_POS_W) != '0) begin
      result.position = {OUT_POS_W{1'b1}};
    end else begin
      result.position = OUT_POS_W'(pos_sel);
    end

    if (res_valid) begin
      depth_nxt = '0;
      idx_nxt   = '0;
      err_nxt   = 1'b0;
    end

    raddr_full = depth_nxt - DW'(2);
    raddr      = raddr_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      idx_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
    end
    top_r        <= top_nxt;
    err_status_r <= err_status_nxt;
    err_pos_r    <= err_pos_nxt;
    err_sym_r    <= err_sym_nxt;
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (depth_r == '0 && idx_r == '0 && !err_r))
    else $error("state not cleared after verdict");

  a_error_freezes_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !res_valid) |=> $stable(depth_r))
    else $error("stack moved after an error");

  a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (depth_r < DW'(STACK_DEPTH) && !err_r))
    else $error("push with full stack or latched error");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_bracket_balance_checker.sv
`timescale 1ns / 100ps

module tb_bracket_balance_checker;
  import bbc_pkg::*;

  localparam int STACK_N = 256;
  localparam int POS_BITS = 16;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 165;
  localparam int LONG_FILL = 40;

  localparam logic [3:0][7:0] OPEN_SET = {CH_LANGLE, CH_LBRACK, CH_LBRACE, CH_LPAREN};
  localparam logic [3:0][7:0] CLOSE_SET = {CH_RANGLE, CH_RBRACK, CH_RBRACE, CH_RPAREN};

  class bracket_scoreboard #(int DEPTH = 256, int PBITS = 16);
    logic [3:0][7:0] open_tab;
    logic [3:0][7:0] close_tab;
    br_code_t        nest[DEPTH];
    int unsigned     depth;
    int unsigned     index;
    int unsigned     pos_max;
    bit              err_seen;
    status_t         err_status;
    int unsigned     err_pos;
    logic [7:0]      err_sym;
    bbc_result_t     verdicts[$];
    int unsigned     fails;

    function new();
      open_tab = {CH_LANGLE, CH_LBRACK, CH_LBRACE, CH_LPAREN};
      close_tab = {CH_RANGLE, CH_RBRACK, CH_RBRACE, CH_RPAREN};
      pos_max = 32'((64'd1 << PBITS) - 64'd1);
      fails = 0;
      clear_string();
    endfunction

    function void clear_string();
      depth = 0;
      index = 0;
      err_seen = 1'b0;
      err_status = ST_BALANCED;
      err_pos = 0;
      err_sym = 8'h00;
    endfunction

    function void latch_error(input status_t st, input int unsigned pos, input logic [7:0] sym);
      err_seen = 1'b1;
      err_status = st;
      err_pos = pos;
      err_sym = sym;
    endfunction

    function int lookup(input logic [3:0][7:0] tab, input logic [7:0] sym);
      for (int k = 0; k < 4; k++)
        if (tab[k] == sym) return k;
      return -1;
    endfunction

    function logic [15:0] clip16(input int unsigned v);
      return (v > 32'h0000_FFFF) ? 16'hFFFF : 16'(v);
    endfunction

    function void note_byte(input logic [7:0] sym, input logic last_b);
      int          op;
      int          cl;
      br_code_t    top;
      bbc_result_t v;
      op = lookup(open_tab, sym);
      cl = lookup(close_tab, sym);
      if (!err_seen) begin
        if (op >= 0) begin
          if (depth >= DEPTH) begin
            latch_error(ST_OVERFLOW, index, sym);
          end else begin
            nest[depth] = br_code_t'(op);
            depth++;
          end
        end else if (cl >= 0) begin
          if (depth == 0) begin
            latch_error(ST_MISSING_OPENER, index, open_tab[cl]);
          end else begin
            top = nest[depth - 1];
            if (top != br_code_t'(cl)) latch_error(ST_WRONG_CLOSER, index, close_tab[top]);
            else depth--;
          end
        end
      end
      if (index < pos_max) index++;
      if (!last_b) return;
      if (err_seen) begin
        v.status = err_status;
        v.position = clip16(err_pos);
        v.expected = err_sym;
      end else if (depth == 0) begin
        v.status = ST_BALANCED;
        v.position = '0;
        v.expected = '0;
      end else begin
        v.status = ST_MISSING_CLOSER;
        v.position = clip16(index);
        v.expected = close_tab[nest[depth - 1]];
      end
      verdicts.push_back(v);
      clear_string();
    endfunction

    function void check_verdict(input logic [2:0] st, input logic [15:0] pos,
                                input logic [7:0] exp_sym);
      bbc_result_t want;
      if (verdicts.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected verdict: status %0d position %0d symbol %02h",
                   st, pos, exp_sym);
        return;
      end
      want = verdicts.pop_front();
      if (3'(want.status) !== st || want.position !== pos || want.expected !== exp_sym) begin
        fails++;
        if (fails <= 10)
          $display("bad verdict: status %0d/%0d position %0d/%0d symbol %02h/%02h (expected/got)",
                   want.status, st, want.position, pos, want.expected, exp_sym);
      end
    endfunction

    function int unsigned outstanding();
      return verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bbc_in_if  in_ch();
  bbc_out_if out_ch();

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_N),
    .POSITION_BITS(POS_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  bracket_scoreboard #(STACK_N, POS_BITS) sb;

  logic [7:0] text[$];
  br_code_t   open_codes[$];
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         rx_hold_req;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #1ms;
    $display("bracket_balance_checker: mismatch");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_verdict(out_ch.status, out_ch.position, out_ch.expected);
      if (in_ch.valid && in_ch.ready)
        sb.note_byte(in_ch.symbol, in_ch.last);
    end
  end

  function automatic bit is_bracket(input logic [7:0] s);
    for (int k = 0; k < 4; k++)
      if (OPEN_SET[k] == s || CLOSE_SET[k] == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] s;
    do s = 8'($urandom_range(255)); while (is_bracket(s));
    return s;
  endfunction

  function automatic logic [7:0] mixed_byte();
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(1)) return OPEN_SET[$urandom_range(3)];
      return CLOSE_SET[$urandom_range(3)];
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input logic [7:0] sym, input logic last_b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.last   <= last_b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++)
      send_item(text[i], i == text.size() - 1);
  endtask

  task automatic send_str(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic push_open();
    br_code_t c;
    c = br_code_t'($urandom_range(3));
    open_codes.push_back(c);
    text.push_back(OPEN_SET[c]);
  endtask

  task automatic pop_close();
    text.push_back(CLOSE_SET[open_codes.pop_back()]);
  endtask

  task automatic close_all();
    while (open_codes.size() > 0) pop_close();
  endtask

  task automatic grow_nested(input int steps, input int max_d);
    int r;
    repeat (steps) begin
      r = $urandom_range(9);
      if (r < 4 && open_codes.size() < max_d) push_open();
      else if (r < 7 && open_codes.size() > 0) pop_close();
      else text.push_back(filler_byte());
    end
  endtask

  task automatic add_tail();
    repeat ($urandom_range(6)) text.push_back(mixed_byte());
  endtask

  task automatic build_random();
    int       pick;
    br_code_t wrong;
    text.delete();
    open_codes.delete();
    pick = $urandom_range(99);
    if (pick < 35) begin
      grow_nested($urandom_range(24), $urandom_range(1, 12));
      close_all();
    end else if (pick < 50) begin
      grow_nested($urandom_range(24), $urandom_range(1, 12));
      if (open_codes.size() == 0) push_open();
      repeat ($urandom_range(open_codes.size() - 1)) pop_close();
    end else if (pick < 65) begin
      grow_nested($urandom_range(24), $urandom_range(1, 12));
      if (open_codes.size() == 0) push_open();
      wrong = open_codes[$] + br_code_t'($urandom_range(1, 3));
      text.push_back(CLOSE_SET[wrong]);
      add_tail();
    end else if (pick < 75) begin
      grow_nested($urandom_range(16), $urandom_range(1, 8));
      close_all();
      text.push_back(CLOSE_SET[$urandom_range(3)]);
      add_tail();
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 20)) text.push_back(mixed_byte());
    end else if (pick < 95) begin
      grow_nested($urandom_range(40, 120), $urandom_range(20, 60));
      close_all();
    end else begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
    end
    if (text.size() == 0) text.push_back(filler_byte());
  endtask

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_random();
      send_text();
      sent += text.size();
    end
  endtask

  task automatic run_directed();
    text = {8'h00};
    send_text();
    text = {8'hFF};
    send_text();
    send_str("([{<>}])");
    send_str(")");
    send_str("(]");
    send_str("[");
    send_str("<>>");
    send_str("{x}");
    send_str("}a(");
  endtask

  task automatic run_deep();
    text.delete();
    open_codes.delete();
    repeat (STACK_N) push_open();
    close_all();
    send_text();
    text.delete();
    repeat (STACK_N + 1) push_open();
    text.push_back(filler_byte());
    text.push_back(CLOSE_SET[0]);
    send_text();
    text.delete();
    open_codes.delete();
    repeat (STACK_N) push_open();
    send_text();
  endtask

  task automatic run_long();
    br_code_t wrong;
    text.delete();
    open_codes.delete();
    push_open();
    repeat (LONG_FILL) text.push_back(filler_byte());
    send_text();
    text.delete();
    open_codes.delete();
    push_open();
    repeat (LONG_FILL) text.push_back(filler_byte());
    wrong = open_codes[$] + br_code_t'($urandom_range(1, 3));
    text.push_back(CLOSE_SET[wrong]);
    repeat (10) text.push_back(mixed_byte());
    send_text();
  endtask

  initial begin
    sb = new();
    rx_hold_req = 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 82;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.symbol <= 8'h00;
    in_ch.last   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_deep();
    run_random(PHASE_BYTES);
    settle();

    tx_idle_pct = 82;
    rx_idle_pct = 8;
    run_random(PHASE_BYTES);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    run_random(PHASE_BYTES);
    settle();
    run_long();
    settle();

    repeat (4) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("bracket_balance_checker: match");
    end else begin
      $display("bracket_balance_checker: mismatch");
    end
    $finish;
  end

endmodule
